// ----- design/lc3x_pkg.sv -----
package lc3x_pkg;

	localparam int MEM_WORDS_DEFAULT = 65536;
	localparam logic [15:0] PC_RESET = 16'h3000;
	localparam logic [2:0] FLAGS_RESET = 3'b010;

	localparam logic [1:0] ST_EXEC = 2'd0;
	localparam logic [1:0] ST_LOADED = 2'd1;
	localparam logic [1:0] ST_UNHANDLED = 2'd2;

	localparam logic [3:0] OP_BR = 4'h0;
	localparam logic [3:0] OP_ADD = 4'h1;
	localparam logic [3:0] OP_LD = 4'h2;
	localparam logic [3:0] OP_ST = 4'h3;
	localparam logic [3:0] OP_JSR = 4'h4;
	localparam logic [3:0] OP_AND = 4'h5;
	localparam logic [3:0] OP_LDR = 4'h6;
	localparam logic [3:0] OP_STR = 4'h7;
	localparam logic [3:0] OP_NOT = 4'h9;
	localparam logic [3:0] OP_LDI = 4'hA;
	localparam logic [3:0] OP_STI = 4'hB;
	localparam logic [3:0] OP_JMP = 4'hC;
	localparam logic [3:0] OP_LEA = 4'hE;

	// Datapath commands issued by the controller.
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_DECODE,
		CMD_MEM_RD,
		CMD_MEM_RD2,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
	} ctl_t;

	typedef struct packed {
		logic indirect;
	} sts_t;

	function automatic logic [2:0] nzp(input logic [15:0] v);
		if (v == 16'd0) return 3'b010;
		else if (v[15]) return 3'b100;
		else return 3'b001;
	endfunction

endpackage

// ----- design/lc3x_ctrl.sv -----
module lc3x_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input lc3x_pkg::sts_t sts,
	output lc3x_pkg::ctl_t ctl,
	output logic busy,
	output logic done
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC = 3'd1;
	localparam logic [2:0] S_RD = 3'd2;
	localparam logic [2:0] S_RD2 = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;

	logic [2:0] state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_DEC;
				S_DEC: state_q <= S_RD;
				S_RD: state_q <= sts.indirect ? S_RD2 : S_FIN;
				S_RD2: state_q <= S_FIN;
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		case (state_q)
			S_DEC: ctl.cmd = lc3x_pkg::CMD_DECODE;
			S_RD: ctl.cmd = lc3x_pkg::CMD_MEM_RD;
			S_RD2: ctl.cmd = lc3x_pkg::CMD_MEM_RD2;
			S_FIN: ctl.cmd = lc3x_pkg::CMD_FINISH;
			default: ctl.cmd = lc3x_pkg::CMD_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_FIN);

	a_start_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> state_q == S_DEC) else $error("no decode");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> state_q == S_IDLE) else $error("fin stuck");
	a_rd2: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD2 |-> $past(state_q) == S_RD) else $error("bad rd2");

endmodule

// ----- design/lc3x_dp.sv -----
module lc3x_dp #(
	parameter int MEM_WORDS = lc3x_pkg::MEM_WORDS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input lc3x_pkg::ctl_t ctl,
	output lc3x_pkg::sts_t sts,
	input logic mode,
	input logic [15:0] instruction,
	input logic [15:0] load_address,
	input logic [15:0] load_data,
	output logic [15:0] next_pc,
	output logic [2:0] flags,
	output logic [1:0] status,
	output logic [15:0] written_value
);

	localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

	logic [15:0] mem [MEM_WORDS];
	logic [15:0] rf_q [8];
	logic [15:0] pc_q;
	logic [2:0] flg_q;

	logic mode_q;
	logic [15:0] ins_q, la_q, ld_q;
	logic [15:0] a_q, b_q, addr_q, rdata_q, res_q;
	logic [15:0] rd_val, rd_addr;

	logic [3:0] op;
	logic [2:0] dr, sr1;
	logic [15:0] off9, off6, off11, opnd2, base;

	assign op = ins_q[15:12];
	assign dr = ins_q[11:9];
	assign sr1 = ins_q[8:6];
	assign off9 = {{7{ins_q[8]}}, ins_q[8:0]};
	assign off6 = {{10{ins_q[5]}}, ins_q[5:0]};
	assign off11 = {{5{ins_q[10]}}, ins_q[10:0]};
	assign opnd2 = ins_q[5] ? {{11{ins_q[4]}}, ins_q[4:0]} : rf_q[ins_q[2:0]];
	assign base = rf_q[sr1];
	assign sts.indirect = !mode_q &&
		((op == lc3x_pkg::OP_LDI) || (op == lc3x_pkg::OP_STI));

	function automatic logic in_range(input logic [15:0] a);
		return ({16'd0, a} < 32'(MEM_WORDS));
	endfunction

	logic is_st;
	assign is_st = (op == lc3x_pkg::OP_ST) || (op == lc3x_pkg::OP_STI) ||
		(op == lc3x_pkg::OP_STR);

	// The second read of an indirect access follows the pointer fetched by the first.
	assign rd_addr = (ctl.cmd == lc3x_pkg::CMD_MEM_RD2) ? rdata_q : addr_q;

	// Memory: one read or one write per cycle, registered read data.
	always_ff @(posedge clk) begin
		if (ctl.cmd == lc3x_pkg::CMD_MEM_RD || ctl.cmd == lc3x_pkg::CMD_MEM_RD2) begin
			rdata_q <= in_range(rd_addr) ? mem[rd_addr[AW-1:0]] : 16'd0;
		end
		if (ctl.cmd == lc3x_pkg::CMD_FINISH) begin
			if (mode_q) begin
				if (in_range(la_q)) mem[la_q[AW-1:0]] <= ld_q;
			end else if (is_st) begin
				if (in_range(a_q)) mem[a_q[AW-1:0]] <= b_q;
			end
		end
	end

	assign rd_val = rdata_q;

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_q <= mode;
			ins_q <= instruction;
			la_q <= load_address;
			ld_q <= load_data;
		end
		case (ctl.cmd)
			lc3x_pkg::CMD_DECODE: begin
				b_q <= rf_q[dr];
				case (op)
					lc3x_pkg::OP_LDR, lc3x_pkg::OP_STR: addr_q <= base + off6;
					default: addr_q <= pc_q + 16'd1 + off9;
				endcase
				case (op)
					lc3x_pkg::OP_ADD: res_q <= base + opnd2;
					lc3x_pkg::OP_AND: res_q <= base & opnd2;
					lc3x_pkg::OP_NOT: res_q <= ~base;
					lc3x_pkg::OP_JMP: res_q <= base;
					lc3x_pkg::OP_JSR: res_q <= ins_q[11] ? pc_q + 16'd1 + off11 : base;
					default: res_q <= pc_q + 16'd1 + off9;
				endcase
			end
			lc3x_pkg::CMD_MEM_RD: a_q <= addr_q;
			lc3x_pkg::CMD_MEM_RD2: begin
				addr_q <= rd_val;
				a_q <= rd_val;
			end
			default: ;
		endcase
	end

	logic [15:0] wv, npc, pc1, reg_v;
	logic wr_reg, wr_flg;
	logic [1:0] stat;

	always_comb begin
		pc1 = pc_q + 16'd1;
		npc = pc1;
		wv = 16'd0;
		reg_v = 16'd0;
		wr_reg = 1'b0;
		wr_flg = 1'b0;
		stat = lc3x_pkg::ST_EXEC;
		if (mode_q) begin
			npc = pc_q;
			wv = ld_q;
			stat = lc3x_pkg::ST_LOADED;
		end else begin
			case (op)
				lc3x_pkg::OP_BR: if ((dr & flg_q) != 3'd0) npc = res_q;
				lc3x_pkg::OP_ADD, lc3x_pkg::OP_AND, lc3x_pkg::OP_NOT,
				lc3x_pkg::OP_LEA: begin
					reg_v = res_q;
					wr_reg = 1'b1;
					wr_flg = 1'b1;
				end
				lc3x_pkg::OP_LD, lc3x_pkg::OP_LDR, lc3x_pkg::OP_LDI: begin
					reg_v = rdata_q;
					wr_reg = 1'b1;
					wr_flg = 1'b1;
				end
				lc3x_pkg::OP_ST, lc3x_pkg::OP_STI, lc3x_pkg::OP_STR: wv = b_q;
				lc3x_pkg::OP_JMP: npc = res_q;
				lc3x_pkg::OP_JSR: begin
					npc = res_q;
					wv = pc1;
				end
				default: stat = lc3x_pkg::ST_UNHANDLED;
			endcase
			if (wr_reg) wv = reg_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= lc3x_pkg::PC_RESET;
			flg_q <= lc3x_pkg::FLAGS_RESET;
			for (int i = 0; i < 8; i++) rf_q[i] <= 16'd0;
		end else if (ctl.cmd == lc3x_pkg::CMD_FINISH) begin
			pc_q <= npc;
			if (wr_flg) flg_q <= lc3x_pkg::nzp(reg_v);
			if (wr_reg) rf_q[dr] <= reg_v;
			if (!mode_q && op == lc3x_pkg::OP_JSR) rf_q[7] <= pc1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cmd == lc3x_pkg::CMD_FINISH) begin
			next_pc <= npc;
			flags <= wr_flg ? lc3x_pkg::nzp(reg_v) : flg_q;
			status <= stat;
			written_value <= wv;
		end
	end

	a_ld_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.cmd == lc3x_pkg::CMD_FINISH && mode_q) |=> $stable(pc_q)) else $error("pc moved");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(flg_q)) else $error("flags");
	a_unh: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.cmd == lc3x_pkg::CMD_FINISH && stat == lc3x_pkg::ST_UNHANDLED)
		|=> pc_q == $past(pc_q) + 16'd1) else $error("unhandled pc");

endmodule

// ----- design/lc3_instruction_execute_top.sv -----
// LC-3 execute unit: one instruction or memory load per transaction.
// Steps: decode, memory read (a second read for LDI/STI indirection), then finish; the
// result strobe is registered from finish. Word memory is single-port: one read per cycle.
// Start is taken only when idle, so transactions do not overlap; busy falls as the result shows.
// Reset (arst_n low) sets PC to 0x3000, clears R0-R7 and sets the Z flag; memory is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle on done.
module lc3_instruction_execute_top #(
	parameter int MEM_WORDS = lc3x_pkg::MEM_WORDS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic mode,
	input logic [15:0] instruction,
	input logic [15:0] load_address,
	input logic [15:0] load_data,
	output logic done,
	output logic [15:0] next_pc,
	output logic [2:0] flags,
	output logic [1:0] status,
	output logic [15:0] written_value
);

	lc3x_pkg::ctl_t ctl;
	lc3x_pkg::sts_t sts;
	logic fin, done_q;

	// The controller sequences decode, memory reads and writeback.
	lc3x_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts),
		.ctl(ctl), .busy(busy), .done(fin)
	);

	// The datapath holds registers, PC, flags and word memory.
	lc3x_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ctl(ctl), .sts(sts), .mode(mode), .instruction(instruction),
		.load_address(load_address), .load_data(load_data),
		.next_pc(next_pc), .flags(flags), .status(status),
		.written_value(written_value)
	);

	// Result registers load at the finish step; the strobe, registered from it, rises with them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= fin;
	end
	assign done = done_q;

endmodule
